// ===== rtl/core/vrms_pkg.sv =====
// ----------------------------------------------------------------------------
// vrms_pkg
// Shared types and constants for the vector rotate-and-mask shifter.
// ----------------------------------------------------------------------------
package vrms_pkg;

    // Operation codes; code 7 is unused and yields a zero result
    typedef enum logic [2:0] {
        OP_HW_LOGIC     = 3'd0,
        OP_HW_ARITH     = 3'd1,
        OP_WORD_LOGIC   = 3'd2,
        OP_WORD_ARITH   = 3'd3,
        OP_QUAD_BYTES   = 3'd4,
        OP_QUAD_BYTES_B = 3'd5,
        OP_QUAD_BITS    = 3'd6
    } op_t;

    localparam int unsigned QW_W      = 128;
    localparam int unsigned HALF_W    = 64;
    localparam int unsigned IMM_W     = 7;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned S_TUSER_W = 4;
    localparam int unsigned S_TDATA_W = 264;
    localparam int unsigned M_TDATA_W = 128;

    // One shift request as held in the input register
    typedef struct packed {
        logic [OP_W-1:0]    req_type;
        logic               use_imm;
        logic [IMM_W-1:0]   imm_count;
        logic [QW_W-1:0]    a;
        logic [QW_W-1:0]    b;
    } req_t;

endpackage

// ===== rtl/core/vector_rotate_and_mask_shifter.sv =====
// ----------------------------------------------------------------------------
// vector_rotate_and_mask_shifter
// 128-bit SIMD rotate-and-mask shift unit with stream interfaces.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output is ready and returns one
// 128-bit result per item. An item passes an input register, one level of lane
// shifters (halfword, word, quadword by bytes or bits) and a result register;
// the result register decouples the two sides, so a new item is taken into an
// empty input register while a finished result waits. Throughput is likewise one
// item per cycle, set by the single-pass shifter between the two registers. Shift
// counts are negated and taken modulo 32 (halfword, quadword bytes), 64 (word)
// or 8 (quadword bits); counts past the lane width give zero or sign fill, and
// a byte count above fifteen gives zero. Operation code 7 returns zero.
// ----------------------------------------------------------------------------
module vector_rotate_and_mask_shifter
    import vrms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // imm_count[6:0], a_hi[70:7], a_lo[134:71], b_hi[198:135], b_lo[262:199], zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // req_type[2:0], use_imm[3]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // r_hi[63:0], r_lo[127:64]
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    req_t             in_req;
    req_t             in_req_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [QW_W-1:0]  out_data_reg;
    logic [QW_W-1:0]  shift_res;
    logic             res_ready;
    logic             in_take;

    // Unpack the stream fields; a and b are {hi, lo}
    always_comb
    begin
        in_req.req_type  = s_axis_tuser[2:0];
        in_req.use_imm   = s_axis_tuser[3];
        in_req.imm_count = s_axis_tdata[6:0];
        in_req.a         = {s_axis_tdata[70:7], s_axis_tdata[134:71]};
        in_req.b         = {s_axis_tdata[198:135], s_axis_tdata[262:199]};
    end

    // Advance the result stage when it is empty or being drained
    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || res_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (res_ready)
            out_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold unless the stage advances
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_req_reg <= in_req;
        if (res_ready && in_valid_reg)
            out_data_reg <= shift_res;
    end

    vrms_shift_core u_core (
        .req    (in_req_reg),
        .result (shift_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    // r_hi in the low half, r_lo above it
    assign m_axis_tdata  = {out_data_reg[HALF_W-1:0], out_data_reg[QW_W-1:HALF_W]};

endmodule

// ===== rtl/core/vrms_shift_core.sv =====
// ----------------------------------------------------------------------------
// vrms_shift_core
// Combinational lane and quadword shifter for one request.
// ----------------------------------------------------------------------------
module vrms_shift_core
    import vrms_pkg::*;
(
    input  req_t              req,
    output logic [QW_W-1:0]   result
);

    localparam int unsigned HW_W    = 16;
    localparam int unsigned HW_N    = QW_W / HW_W;
    localparam int unsigned WD_W    = 32;
    localparam int unsigned WD_N    = QW_W / WD_W;

    logic [QW_W-1:0] hw_res;
    logic [QW_W-1:0] wd_res;
    logic [QW_W-1:0] byte_res;
    logic [QW_W-1:0] bit_res;
    logic            arith;
    logic [31:0]     pref;

    assign arith = req.req_type[0];
    assign pref  = req.b[QW_W-1 -: 32];

    // Halfword lanes: extended sign shifts out as fill, so counts of 16..31 need no
    // special case
    always_comb
    begin
        logic [4:0]      cnt;
        logic [4:0]      s;
        logic [HW_W:0]   ext;
        for (int i = 0; i < HW_N; i++)
        begin
            cnt = req.use_imm ? req.imm_count[4:0] : req.b[i*HW_W +: 5];
            s   = 5'(5'd0 - cnt);
            ext = {arith & req.a[i*HW_W + HW_W - 1], req.a[i*HW_W +: HW_W]};
            hw_res[i*HW_W +: HW_W] = HW_W'($signed(ext) >>> s);
        end
    end

    // Word lanes, count modulo 64
    always_comb
    begin
        logic [5:0]      cnt;
        logic [5:0]      s;
        logic [WD_W:0]   ext;
        for (int i = 0; i < WD_N; i++)
        begin
            cnt = req.use_imm ? req.imm_count[5:0] : req.b[i*WD_W +: 6];
            s   = 6'(6'd0 - cnt);
            ext = {arith & req.a[i*WD_W + WD_W - 1], req.a[i*WD_W +: WD_W]};
            wd_res[i*WD_W +: WD_W] = WD_W'($signed(ext) >>> s);
        end
    end

    // Quadword byte shift; counts above fifteen bytes clear the result
    always_comb
    begin
        logic [4:0] cnt;
        logic [4:0] s;
        if (req.use_imm)
            cnt = req.imm_count[4:0];
        else if (req.req_type == OP_QUAD_BYTES_B)
            cnt = pref[7:3];
        else
            cnt = pref[4:0];
        s = 5'(5'd0 - cnt);
        if (s[4])
            byte_res = '0;
        else
            byte_res = req.a >> {s[3:0], 3'b000};
    end

    // Quadword bit shift, count modulo 8
    always_comb
    begin
        logic [2:0] cnt;
        logic [2:0] s;
        cnt     = req.use_imm ? req.imm_count[2:0] : pref[2:0];
        s       = 3'(3'd0 - cnt);
        bit_res = req.a >> s;
    end

    always_comb
    begin
        unique case (op_t'(req.req_type))
            OP_HW_LOGIC, OP_HW_ARITH:        result = hw_res;
            OP_WORD_LOGIC, OP_WORD_ARITH:    result = wd_res;
            OP_QUAD_BYTES, OP_QUAD_BYTES_B:  result = byte_res;
            OP_QUAD_BITS:                    result = bit_res;
            default:                         result = '0;
        endcase
    end

endmodule

// ===== rtl/core/vrms_checker.sv =====
// ----------------------------------------------------------------------------
// vrms_checker
// Port-level checks for the vector rotate-and-mask shifter.
// ----------------------------------------------------------------------------
module vrms_checker
    import vrms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata
);

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // With no result waiting, the input side must be open
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // An accepted item passes the input and result registers and reaches the output when it is ready in between
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted item did not reach output");

    // Output ready alone keeps the input open
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output drains");

endmodule

bind vector_rotate_and_mask_shifter vrms_checker u_vrms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
